// ===== rtl/net_pkg.sv =====
`timescale 1ns / 1ps

package net_pkg;

    // Payload of one input item
    typedef struct packed {
        logic signed [15:0] air_temp;
        logic signed [15:0] humidity;
        logic signed [15:0] wind_speed;
    } t_in;

    // Payload of one result item
    typedef struct packed {
        logic signed [15:0] net_temp;
        logic               valid_res;
    } t_out;

    // Classified item as it leaves the front end
    typedef struct packed {
        logic               ok;
        logic signed [15:0] t;
        logic signed [15:0] h;
        logic signed [15:0] w;
    } t_item;

    // Queue head handed to the back end
    typedef struct packed {
        logic  vld;
        t_item item;
    } t_hand;

    // Input range limits, inclusive
    localparam logic signed [15:0] HUM_MAX  = 16'sd10010;
    localparam logic signed [15:0] WIND_MAX = 16'sd13000;
    localparam logic signed [15:0] TEMP_LIM = 16'sd10000;
    localparam logic signed [15:0] TEMP_MIN = -16'sd10000;
    localparam logic signed [15:0] HUM_ONE  = 16'sd10000;
    localparam logic signed [15:0] T_BODY   = 16'sd3700;

    localparam int Q_FRAC  = 24;
    localparam int Q_DEPTH = 2;

    // Long divider for the two variable divisors: one quotient bit per stage
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 40;
    localparam int DIV_LAT = DIV_NW;

    // Constant divisors: floor(n / k) = (n * ceil(2^s / k)) >> s,
    // exact while n < 2^s / 2^ceil(log2 k)
    localparam int CM_LAT = 3;
    localparam int S_X    = 69;   // n = v * 2^48 < 2^62, k = 100
    localparam int S_B    = 49;   // n = v * sqrt(v) < 2^42, k = 100
    localparam int S_DD   = 64;   // n < 2^44, k = 10^6
    localparam int S_L    = 76;   // n < 2^56, k = 10^6
    localparam logic [63:0] M_X  = 64'(((128'd1 << S_X) + 128'd99) / 128'd100);
    localparam logic [63:0] M_B  = 64'(((128'd1 << S_B) + 128'd99) / 128'd100);
    localparam logic [63:0] M_DD = 64'(((128'd1 << S_DD) + 128'd999999) / 128'd1000000);
    localparam logic [63:0] M_L  = 64'(((128'd1 << S_L) + 128'd999999) / 128'd1000000);

    // Square root: radicand and root widths; one root bit per stage
    localparam int SQ_IW   = 64;
    localparam int SQ_RW   = SQ_IW / 2;
    localparam int SQ_REMW = SQ_RW + 2;
    localparam int SQ_LAT  = SQ_RW;

    // Signed working width of the final combine
    localparam int R_W = 44;

    // Back end schedule, cycles after the item enters the line
    localparam int C_A_IN   = CM_LAT;
    localparam int C_M      = C_A_IN + SQ_LAT;
    localparam int C_B_IN   = C_M + 1;
    localparam int C_C_IN   = C_B_IN + CM_LAT;
    localparam int C_DEN    = C_C_IN + SQ_LAT;
    localparam int C_INV    = C_DEN + 2;
    localparam int C_D      = C_INV + DIV_LAT;
    localparam int C_DD     = C_D - CM_LAT;
    localparam int C_QP     = C_D + 1;
    localparam int C_QIN    = C_QP + 1;
    localparam int C_QS     = C_QIN + DIV_LAT;
    localparam int C_LP     = C_QS - CM_LAT - 1;
    localparam int C_R      = C_QS + 1;
    localparam int C_OUT    = C_R + 1;
    localparam int LINE_LEN = C_OUT + 1;

    // Accept edge to result strobe edge: queue, line, output register
    localparam int NET_LAT = LINE_LEN + 2;

endpackage

// ===== rtl/net_div.sv =====
`timescale 1ns / 1ps

module net_div (
    input  logic                       i_clk,
    input  logic [net_pkg::DIV_NW-1:0] i_num,
    input  logic [net_pkg::DIV_DW-1:0] i_den,
    output logic [net_pkg::DIV_NW-1:0] o_quo
);

    localparam int NW = net_pkg::DIV_NW;
    localparam int DW = net_pkg::DIV_DW;

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic [DW-1:0] n_rem [NW];
    logic [NW-1:0] n_nq  [NW];
    logic [DW-1:0] n_den [NW];
    logic [DW-1:0] w_prem [NW];
    logic [NW-1:0] w_pnq  [NW];
    logic [DW:0]   w_sh   [NW];
    logic          w_ge   [NW];

    // Numerator shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
        w_prem[0] = '0;
        w_pnq[0]  = i_num;
        n_den[0]  = i_den;
        for (int i = 1; i < NW; i++) begin
            w_prem[i] = r_rem[i-1];
            w_pnq[i]  = r_nq[i-1];
            n_den[i]  = r_den[i-1];
        end
        for (int i = 0; i < NW; i++) begin
            w_sh[i]  = {w_prem[i], w_pnq[i][NW-1]};
            w_ge[i]  = w_sh[i] >= {1'b0, n_den[i]};
            n_rem[i] = w_ge[i] ? DW'(w_sh[i] - {1'b0, n_den[i]}) : w_sh[i][DW-1:0];
            n_nq[i]  = {w_pnq[i][NW-2:0], w_ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NW; i++) begin
            r_rem[i] <= n_rem[i];
            r_nq[i]  <= n_nq[i];
            r_den[i] <= n_den[i];
        end
    end

    assign o_quo = r_nq[NW-1];

endmodule

// ===== rtl/net_sqrt.sv =====
`timescale 1ns / 1ps

module net_sqrt (
    input  logic                      i_clk,
    input  logic [net_pkg::SQ_IW-1:0] i_rad,
    output logic [net_pkg::SQ_RW-1:0] o_root
);

    localparam int IW = net_pkg::SQ_IW;
    localparam int RW = net_pkg::SQ_RW;
    localparam int MW = net_pkg::SQ_REMW;

    logic [MW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [IW-1:0] r_rad  [RW];
    logic [MW-1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];
    logic [IW-1:0] n_rad  [RW];
    logic [MW-1:0] w_prem [RW];
    logic [RW-1:0] w_proot [RW];
    logic [IW-1:0] w_prad [RW];
    logic [MW+1:0] w_cur  [RW];
    logic [MW+1:0] w_try  [RW];
    logic          w_ge   [RW];

    // Two radicand bits per stage, trial subtract of 4*root+1
    always_comb begin
        w_prem[0]  = '0;
        w_proot[0] = '0;
        w_prad[0]  = i_rad;
        for (int i = 1; i < RW; i++) begin
            w_prem[i]  = r_rem[i-1];
            w_proot[i] = r_root[i-1];
            w_prad[i]  = r_rad[i-1];
        end
        for (int i = 0; i < RW; i++) begin
            w_cur[i]  = {w_prem[i], w_prad[i][IW-1:IW-2]};
            w_try[i]  = {2'b00, w_proot[i], 2'b01};
            w_ge[i]   = w_cur[i] >= w_try[i];
            n_rem[i]  = w_ge[i] ? MW'(w_cur[i] - w_try[i]) : w_cur[i][MW-1:0];
            n_root[i] = {w_proot[i][RW-2:0], w_ge[i]};
            n_rad[i]  = {w_prad[i][IW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RW; i++) begin
            r_rem[i]  <= n_rem[i];
            r_root[i] <= n_root[i];
            r_rad[i]  <= n_rad[i];
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== rtl/net_front.sv =====
`timescale 1ns / 1ps

module net_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  net_pkg::t_in   i_item,
    output net_pkg::t_hand o_hand
);

    localparam int QAW = (net_pkg::Q_DEPTH > 1) ? $clog2(net_pkg::Q_DEPTH) : 1;
    localparam int CW  = $clog2(net_pkg::Q_DEPTH + 1);

    net_pkg::t_item r_q [net_pkg::Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [CW-1:0]  r_cnt;
    logic           r_live;
    logic [QAW-1:0] n_wp;
    logic [QAW-1:0] n_rp;
    logic           w_push;
    logic           w_pop;
    logic           w_ok;
    net_pkg::t_item w_item;

    always_comb begin
        w_ok = (i_item.humidity >= 16'sd0) && (i_item.humidity <= net_pkg::HUM_MAX) &&
               (i_item.wind_speed >= 16'sd0) && (i_item.wind_speed <= net_pkg::WIND_MAX) &&
               (i_item.air_temp >= net_pkg::TEMP_MIN) && (i_item.air_temp <= net_pkg::TEMP_LIM);
        // zero the fields of an out-of-range item so the math stays tame
        w_item.ok = w_ok;
        w_item.t  = w_ok ? i_item.air_temp : 16'sd0;
        w_item.h  = w_ok ? i_item.humidity : 16'sd0;
        w_item.w  = w_ok ? i_item.wind_speed : 16'sd0;
    end

    assign o_busy = !r_live || (r_cnt == CW'(net_pkg::Q_DEPTH));
    assign w_push = i_start && !o_busy;
    assign w_pop  = r_cnt != '0;
    assign n_wp   = (r_wp == QAW'(net_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp   = (r_rp == QAW'(net_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_cnt  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            r_live <= 1'b1;
            if (w_push) begin
                r_wp <= n_wp;
            end
            if (w_pop) begin
                r_rp <= n_rp;
            end
            r_cnt <= CW'(r_cnt + CW'(w_push) - CW'(w_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // back end never stalls: hand the head over every cycle it exists
    assign o_hand.vld  = w_pop;
    assign o_hand.item = r_q[r_rp];

endmodule

// ===== rtl/net_back.sv =====
`timescale 1ns / 1ps

module net_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  net_pkg::t_hand i_hand,
    output logic           o_strobe,
    output net_pkg::t_out  o_result
);

    localparam int NW = net_pkg::DIV_NW;
    localparam int DW = net_pkg::DIV_DW;
    localparam int RW = net_pkg::R_W;
    localparam int QF = net_pkg::Q_FRAC;
    localparam int LL = net_pkg::LINE_LEN;
    localparam logic [RW-1:0] R_BODY   = RW'(3700) << QF;
    localparam logic [RW-1:0] R_HALF   = RW'(1) << (QF - 1);
    localparam logic [NW-1:0] MILLION_H = NW'(500000);

    // reciprocal multipliers for the constant divisors
    localparam int NC   = 4;
    localparam int U_X  = 0;
    localparam int U_B  = 1;
    localparam int U_DD = 2;
    localparam int U_L  = 3;

    logic           r_act  [LL];
    net_pkg::t_item r_line [LL];

    logic [NW-1:0] x_quo, b_quo, inv_quo, dd_quo, q_quo, l_quo;
    logic [net_pkg::SQ_RW-1:0] a_root, c_root;

    logic [NW-1:0]   w_ca   [NC];
    logic [NW-1:0]   w_cm   [NC];
    logic [NW-1:0]   r_pll  [NC];
    logic [NW-1:0]   r_plh  [NC];
    logic [NW-1:0]   r_phl  [NC];
    logic [NW-1:0]   r_phh  [NC];
    logic [NW:0]     r_pmid [NC];
    logic [2*NW-1:0] r_plo  [NC];
    logic [2*NW-1:0] r_prod [NC];

    logic [NW-1:0] r_m;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num2;
    logic [DW-1:0] r_den2;
    logic [DW-1:0] r_d;
    logic [NW-1:0] r_qnum;
    logic [DW-1:0] r_qden;
    logic [39:0]   r_lmag;
    logic [RW-1:0] r_qs;
    logic [RW-1:0] r_ls;
    logic [RW-1:0] r_r;
    logic          r_strobe;
    net_pkg::t_out r_out;

    logic [19:0]   w_ddb;
    logic [NW-1:0] w_ddnum;
    logic [16:0]   w_tdiff;
    logic [15:0]   w_qmag;
    logic [15:0]   w_tmag;
    logic [16:0]   w_hd;
    logic [15:0]   w_hmag;
    logic [RW-1:0] w_qq, w_lq;
    logic          w_qneg, w_lneg;
    logic          w_rneg;
    logic [RW-1:0] w_rmag;
    logic [RW-1:0] w_rsum;
    logic [19:0]   w_rq;
    logic [15:0]   w_sat;

    // Shift line of item tags; each step taps it at its own cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LL; i++) begin
                r_act[i] <= 1'b0;
            end
        end else begin
            r_act[0] <= i_hand.vld;
            for (int i = 1; i < LL; i++) begin
                r_act[i] <= r_act[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_hand.item;
        for (int i = 1; i < LL; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    // x = v * 2^48 / 100 in Q48, and v^1.5 = v * sqrt(v) / 100 in Q24
    always_comb begin
        w_ca[U_X]  = {r_line[0].w, {(2*QF){1'b0}}};
        w_cm[U_X]  = net_pkg::M_X;
        w_ca[U_B]  = r_m;
        w_cm[U_B]  = net_pkg::M_B;
        w_ca[U_DD] = w_ddnum;
        w_cm[U_DD] = net_pkg::M_DD;
        w_ca[U_L]  = {r_lmag, {QF{1'b0}}} + MILLION_H;
        w_cm[U_L]  = net_pkg::M_L;
    end

    // split each 64x64 product into four 32x32 parts, then sum them through r_pmid and r_plo into r_prod
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NC; k++) begin
            r_pll[k]  <= NW'(w_ca[k][31:0])  * NW'(w_cm[k][31:0]);
            r_plh[k]  <= NW'(w_ca[k][31:0])  * NW'(w_cm[k][63:32]);
            r_phl[k]  <= NW'(w_ca[k][63:32]) * NW'(w_cm[k][31:0]);
            r_phh[k]  <= NW'(w_ca[k][63:32]) * NW'(w_cm[k][63:32]);
            r_pmid[k] <= (NW+1)'(r_plh[k]) + (NW+1)'(r_phl[k]);
            r_plo[k]  <= {r_phh[k], r_pll[k]};
            r_prod[k] <= r_plo[k] + ((2*NW)'(r_pmid[k]) << 32);
        end
    end

    assign x_quo  = NW'(r_prod[U_X] >> net_pkg::S_X);
    assign b_quo  = NW'(r_prod[U_B] >> net_pkg::S_B);
    assign dd_quo = NW'(r_prod[U_DD] >> net_pkg::S_DD);
    assign l_quo  = NW'(r_prod[U_L] >> net_pkg::S_L);

    net_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_rad  (x_quo),
        .o_root (a_root)
    );

    net_sqrt u_sqrt_c (
        .i_clk  (i_clk),
        .i_rad  ({b_quo[NW-QF-1:0], {QF{1'b0}}}),
        .o_root (c_root)
    );

    net_div u_div_inv (
        .i_clk (i_clk),
        .i_num (r_num2),
        .i_den (r_den2),
        .o_quo (inv_quo)
    );

    always_comb begin
        w_ddb   = 20'd680000 - 20'({4'd0, r_line[net_pkg::C_DD].h} * 20'd14);
        w_ddnum = {20'd0, w_ddb, {QF{1'b0}}} + MILLION_H;
    end

    always_comb begin
        w_tdiff = 17'd3700 - {r_line[net_pkg::C_QP].t[15], r_line[net_pkg::C_QP].t};
        w_qmag  = w_tdiff[16] ? 16'(-w_tdiff) : w_tdiff[15:0];
        w_tmag  = r_line[net_pkg::C_LP].t[15] ? 16'(-r_line[net_pkg::C_LP].t)
                                              : r_line[net_pkg::C_LP].t;
        w_hd    = 17'd10000 - {r_line[net_pkg::C_LP].h[15], r_line[net_pkg::C_LP].h};
        w_hmag  = w_hd[16] ? 16'(-w_hd) : w_hd[15:0];
    end

    net_div u_div_q (
        .i_clk (i_clk),
        .i_num (r_qnum),
        .i_den (r_qden),
        .o_quo (q_quo)
    );

    always_comb begin
        w_qneg = r_line[net_pkg::C_QS].t > net_pkg::T_BODY;
        w_lneg = (r_line[net_pkg::C_QS].t < 16'sd0) ^
                 (r_line[net_pkg::C_QS].h > net_pkg::HUM_ONE);
        w_qq   = {1'b0, q_quo[RW-2:0]};
        w_lq   = {1'b0, l_quo[RW-2:0]};
    end

    // round to nearest, ties away from zero, then clamp to 16 bits
    always_comb begin
        w_rneg = r_r[RW-1];
        w_rmag = w_rneg ? -r_r : r_r;
        w_rsum = w_rmag + R_HALF;
        w_rq   = w_rsum[QF+19:QF];
        if (!w_rneg) begin
            w_sat = (w_rq > 20'd32767) ? 16'h7fff : w_rq[15:0];
        end else begin
            w_sat = (w_rq > 20'd32768) ? 16'h8000 : 16'(-w_rq[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= NW'(48'(r_line[net_pkg::C_M].w) * 48'(a_root));
        r_den  <= (DW'(176) << QF) + DW'(c_root) * DW'(140);
        r_num2 <= (NW'(100) << (2*QF)) + NW'(r_den >> 1);
        r_den2 <= r_den;
        r_d    <= dd_quo[DW-1:0] + inv_quo[DW-1:0];
        r_qnum <= {w_qmag, {(2*QF){1'b0}}} + NW'(r_d >> 1);
        r_qden <= r_d;
        r_lmag <= 40'(w_tmag) * 40'(w_hmag) * 40'd29;
        r_qs   <= w_qneg ? -w_qq : w_qq;
        r_ls   <= w_lneg ? -w_lq : w_lq;
        r_r    <= R_BODY - r_qs - r_ls;
        r_out.valid_res <= r_line[net_pkg::C_OUT].ok;
        r_out.net_temp  <= r_line[net_pkg::C_OUT].ok ? w_sat : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act[net_pkg::C_OUT];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ===== rtl/net_effective_temperature.sv =====
`timescale 1ns / 1ps
// Net Effective Temperature from air temperature, humidity and wind speed.
//
// Input: drive i_item and raise start; the item is taken at a clock edge
// where start is high and busy is low. busy is high during reset and for
// the cycle after it, otherwise low: one item may be taken every cycle.
// Output: each item gives one result on o_result, shown for exactly one
// cycle with o_strobe high, in the order the items were taken. The
// receiver has no way to hold results off and must take each one.
// Datapath: two 64-stage long dividers in series (one quotient bit per
// stage), two 32-stage root units and four reciprocal multipliers for
// the constant divisors; throughput is one item per cycle.
// Items with humidity outside 0..100.10 %, wind outside 0..130 m/s or
// temperature outside -100..100 degC give valid_res 0 and net_temp 0.
// Reset (synchronous, active low) drops every item in flight.

module net_effective_temperature (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  net_pkg::t_in  i_item,
    output logic          o_strobe,
    output net_pkg::t_out o_result
);

    net_pkg::t_hand w_hand;

    net_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_item  (i_item),
        .o_hand  (w_hand)
    );

    net_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hand   (w_hand),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== rtl/net_chk.sv =====
`timescale 1ns / 1ps

module net_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input net_pkg::t_in  i_item,
    input logic          o_strobe,
    input net_pkg::t_out o_result
);

    logic w_acc;
    logic w_in_ok;

    assign w_acc   = start && !busy;
    assign w_in_ok = (i_item.humidity >= 16'sd0) && (i_item.humidity <= net_pkg::HUM_MAX) &&
                     (i_item.wind_speed >= 16'sd0) &&
                     (i_item.wind_speed <= net_pkg::WIND_MAX) &&
                     (i_item.air_temp >= net_pkg::TEMP_MIN) &&
                     (i_item.air_temp <= net_pkg::TEMP_LIM);

    // every result belongs to an item taken a fixed latency earlier
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, net_pkg::NET_LAT))
        else $error("result strobe does not match accepted item");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.valid_res) |-> (o_result.net_temp == 16'sd0))
        else $error("invalid result with nonzero temperature");

    a_flag_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc && !w_in_ok, net_pkg::NET_LAT) |-> (o_strobe && !o_result.valid_res))
        else $error("out-of-range item flagged valid");

    a_flag_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc && w_in_ok, net_pkg::NET_LAT) |-> (o_strobe && o_result.valid_res))
        else $error("in-range item flagged invalid");

endmodule

bind net_effective_temperature net_chk u_net_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
